// File: src/lrsg_pkg.sv
// ----------------------------------------------------------------------------
// lrsg_pkg
// Shared types, constants, saturation helpers and the microcode table of the
// LQR steering gain unit.
// ----------------------------------------------------------------------------
package lrsg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TIME_STEP  = 3'd0,
    REG_WHEELBASE  = 3'd1,
    REG_Q_LATERAL  = 3'd2,
    REG_Q_HEADING  = 3'd3,
    REG_R_STEER    = 3'd4,
    REG_R_SECOND   = 3'd5,
    REG_TOLERANCE  = 3'd6,
    REG_MAX_ITER   = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 31;

  // Register values after reset.
  localparam logic [16:0] RST_TIME_STEP = 17'd6554;
  localparam logic [19:0] RST_WHEELBASE = 20'd170394;
  localparam logic [30:0] RST_Q_LATERAL = 31'd6553600;
  localparam logic [30:0] RST_Q_HEADING = 31'd6553600;
  localparam logic [30:0] RST_R_STEER   = 31'd6553600;
  localparam logic [30:0] RST_TOLERANCE = 31'd66;
  localparam logic [10:0] RST_MAX_ITER  = 11'd100;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Microcode operation codes.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB,
    OP_ADDD,
    OP_NEGS,
    OP_COMMIT
  } op_t;

  // Operand sources.
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_V, SRC_DT, SRC_L, SRC_C, SRC_B,
    SRC_P00, SRC_P01, SRC_P11, SRC_Q1, SRC_Q2, SRC_R, SRC_D,
    SRC_Y0, SRC_Y1, SRC_TA, SRC_TB, SRC_T, SRC_N11,
    SRC_K0, SRC_K1, SRC_E0, SRC_E1
  } src_t;

  // Result destinations.
  typedef enum logic [3:0] {
    DST_NONE, DST_C, DST_B, DST_D, DST_Y0, DST_Y1, DST_TA, DST_TB,
    DST_T, DST_N00, DST_N01, DST_N11, DST_K0, DST_K1, DST_U
  } dst_t;

  // Sequencing after a step.
  typedef enum logic [2:0] {
    BR_SEQ,
    BR_LOOP,
    BR_TERMS,
    BR_BACK,
    BR_END
  } br_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    src_t c;
    dst_t dst;
    br_t  br;
  } uop_t;

  typedef logic [4:0] pc_t;

  localparam pc_t PC_CHECK = 5'd2;
  localparam pc_t PC_TERMS = 5'd3;
  localparam pc_t PC_ITER  = 5'd10;
  localparam pc_t PC_FINAL = 5'd23;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] m;
    m = x[31] ? 32'(-x) : 32'(x);
    return m;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 64'h0000_0000_8000_0000) r = SAT_MIN;
      else r = -$signed(m[31:0]);
    end else begin
      if (m > 64'h0000_0000_7FFF_FFFF) r = SAT_MAX;
      else r = $signed(m[31:0]);
    end
    return r;
  endfunction

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat_sum(input logic signed [33:0] s);
    logic signed [31:0] r;
    if (s > 34'sd2147483647) r = SAT_MAX;
    else if (s < -34'sd2147483648) r = SAT_MIN;
    else r = s[31:0];
    return r;
  endfunction

  // Microcode: model setup, the gain terms, one Riccati update, final gains.
  function automatic uop_t micro_rom(input pc_t pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MUL,    SRC_V,    SRC_DT,   SRC_ZERO, DST_C,    BR_SEQ};
      5'd1:  u = '{OP_DIV,    SRC_C,    SRC_ONE,  SRC_L,    DST_B,    BR_SEQ};
      5'd2:  u = '{OP_NOP,    SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_NONE, BR_LOOP};
      5'd3:  u = '{OP_MUL,    SRC_B,    SRC_P00,  SRC_ZERO, DST_TA,   BR_SEQ};
      5'd4:  u = '{OP_MUL,    SRC_B,    SRC_TA,   SRC_ZERO, DST_TA,   BR_SEQ};
      5'd5:  u = '{OP_ADDD,   SRC_R,    SRC_TA,   SRC_ZERO, DST_D,    BR_SEQ};
      5'd6:  u = '{OP_MUL,    SRC_C,    SRC_P01,  SRC_ZERO, DST_TA,   BR_SEQ};
      5'd7:  u = '{OP_ADD,    SRC_P00,  SRC_TA,   SRC_ZERO, DST_TA,   BR_SEQ};
      5'd8:  u = '{OP_MUL,    SRC_B,    SRC_TA,   SRC_ZERO, DST_Y0,   BR_SEQ};
      5'd9:  u = '{OP_MUL,    SRC_B,    SRC_P01,  SRC_ZERO, DST_Y1,   BR_TERMS};
      5'd10: u = '{OP_MUL,    SRC_C,    SRC_P11,  SRC_ZERO, DST_TA,   BR_SEQ};
      5'd11: u = '{OP_ADD,    SRC_P01,  SRC_TA,   SRC_ZERO, DST_T,    BR_SEQ};
      5'd12: u = '{OP_MUL,    SRC_C,    SRC_P01,  SRC_ZERO, DST_TA,   BR_SEQ};
      5'd13: u = '{OP_MUL,    SRC_C,    SRC_T,    SRC_ZERO, DST_TB,   BR_SEQ};
      5'd14: u = '{OP_ADD,    SRC_P00,  SRC_TA,   SRC_TB,   DST_TA,   BR_SEQ};
      5'd15: u = '{OP_DIV,    SRC_Y0,   SRC_Y0,   SRC_D,    DST_TB,   BR_SEQ};
      5'd16: u = '{OP_SUB,    SRC_TA,   SRC_Q1,   SRC_TB,   DST_N00,  BR_SEQ};
      5'd17: u = '{OP_DIV,    SRC_Y0,   SRC_Y1,   SRC_D,    DST_TB,   BR_SEQ};
      5'd18: u = '{OP_SUB,    SRC_T,    SRC_ZERO, SRC_TB,   DST_N01,  BR_SEQ};
      5'd19: u = '{OP_DIV,    SRC_Y1,   SRC_Y1,   SRC_D,    DST_TB,   BR_SEQ};
      5'd20: u = '{OP_SUB,    SRC_P11,  SRC_ZERO, SRC_TB,   DST_N11,  BR_SEQ};
      5'd21: u = '{OP_ADD,    SRC_N11,  SRC_Q2,   SRC_ZERO, DST_N11,  BR_SEQ};
      5'd22: u = '{OP_COMMIT, SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_NONE, BR_BACK};
      5'd23: u = '{OP_DIV,    SRC_Y0,   SRC_ONE,  SRC_D,    DST_K0,   BR_SEQ};
      5'd24: u = '{OP_DIV,    SRC_Y1,   SRC_ONE,  SRC_D,    DST_K1,   BR_SEQ};
      5'd25: u = '{OP_MUL,    SRC_K0,   SRC_E0,   SRC_ZERO, DST_TA,   BR_SEQ};
      5'd26: u = '{OP_MUL,    SRC_K1,   SRC_E1,   SRC_ZERO, DST_TB,   BR_SEQ};
      5'd27: u = '{OP_NEGS,   SRC_TA,   SRC_TB,   SRC_ZERO, DST_U,    BR_END};
      default: u = '{OP_NOP,  SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_NONE, BR_END};
    endcase
    return u;
  endfunction

endpackage

// File: src/lrsg_mul.sv
// ----------------------------------------------------------------------------
// lrsg_mul
// Shared 32x32 magnitude multiplier with a registered product; gives the raw
// product for division and the rounded, saturated fixed-point product.
// ----------------------------------------------------------------------------
module lrsg_mul import lrsg_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic               done,
  output logic [63:0]        product,
  output logic               prod_neg,
  output logic signed [31:0] result
);

  localparam logic [63:0] RND = 64'(1) << (FRAC_BITS - 1);

  logic [63:0] prod_r;
  logic        neg_r;
  logic        done_r;

  // Product of magnitudes and the sign of the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      prod_r <= 64'(mag32(op_a)) * 64'(mag32(op_b));
      neg_r  <= op_a[31] ^ op_b[31];
    end
  end

  // Round to nearest, ties away from zero, then saturate.
  assign result   = sat_mag((prod_r + RND) >> FRAC_BITS, neg_r);
  assign product  = prod_r;
  assign prod_neg = neg_r;
  assign done     = done_r;

endmodule

// File: src/lrsg_div.sv
// ----------------------------------------------------------------------------
// lrsg_div
// Restoring divider, one quotient bit per cycle, with an early saturation
// check; divides a 64-bit magnitude by a positive 32-bit divisor.
// ----------------------------------------------------------------------------
module lrsg_div import lrsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        num,
  input  logic [31:0]        den,
  input  logic               neg,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic        ovf_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [31:0] low_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_dif;
  logic        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_r, low_r[31]};
    rem_dif = rem_sh - {1'b0, den_r};
    fits    = rem_sh >= {1'b0, den_r};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // A high half at or above the divisor means the quotient overflows.
        busy_r <= num[63:32] < den;
        done_r <= num[63:32] >= den;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      neg_r <= neg;
      ovf_r <= num[63:32] >= den;
      rem_r <= num[63:32];
      low_r <= num[31:0];
      cnt_r <= 5'd31;
    end else if (busy_r) begin
      rem_r <= fits ? rem_dif[31:0] : rem_sh[31:0];
      low_r <= {low_r[30:0], fits};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign quotient = ovf_r ? sat_mag(64'h0000_0001_0000_0000, neg_r)
                          : sat_mag(64'(low_r), neg_r);
  assign done     = done_r;

endmodule

// File: src/lqr_riccati_steering_gain_unit.sv
// ----------------------------------------------------------------------------
// lqr_riccati_steering_gain_unit
// Steering gain by discrete LQR: Riccati iteration on a 2x2 lateral model in
// saturating fixed point, run by a microcoded sequencer over one shared
// multiplier, one shared divider and a saturating adder.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall    speed, lateral/heading error
//   out_     output     out_valid / out_stall  command, two gains, count, flag
//   cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
// The next transaction is taken only after the previous result has been
// loaded into the output register. Each update holds three divisions in the
// shared divider, which dominates. Reset is synchronous and active low; it
// sets the control, count and configuration registers, the latter to their
// documented values, but not the working registers or the result data.
// The input is taken only while no solve runs; a finished result waits in
// the output register while the next one starts.
// ----------------------------------------------------------------------------
module lqr_riccati_steering_gain_unit import lrsg_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ITER_LIMIT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [21:0] in_speed,
  input  logic signed [20:0] in_lateral_error,
  input  logic signed [20:0] in_heading_error,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_steer_command,
  output logic signed [31:0] out_gain_lateral,
  output logic signed [31:0] out_gain_heading,
  output logic [10:0]        out_iterations_done,
  output logic               out_converged,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  localparam int unsigned NW = $clog2(ITER_LIMIT + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MULW  = 5'b00100,
    ST_DIVW  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  // Configuration registers.
  logic [16:0] time_step_r;
  logic [19:0] wheelbase_r;
  logic [30:0] q_lateral_r, q_heading_r, r_steer_r, tolerance_r;
  logic [10:0] max_iter_r;

  // Sequencer state.
  state_t        state_r, state_nxt;
  pc_t           pc_r, pc_nxt;
  logic          final_r, final_nxt;
  logic [NW-1:0] n_r;
  logic          conv_r;

  // Working registers.
  logic signed [31:0] v_r, e0_r, e1_r;
  logic signed [31:0] c_r, b_r, d_r, y0_r, y1_r, ta_r, tb_r, t_r;
  logic signed [31:0] p00_r, p01_r, p11_r, n00_r, n01_r, n11_r;
  logic signed [31:0] k0_r, k1_r, u_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_cmd_r, out_k0_r, out_k1_r;
  logic [10:0]        out_n_r;
  logic               out_conv_r;

  uop_t               uop;
  logic signed [31:0] opa, opb, opc;
  logic signed [31:0] alu_res, wr_val;
  logic signed [33:0] sa, sb, sc;
  logic               step_done, wr_en, in_take, out_load;
  logic               mul_start, mul_done, mul_neg, div_start, div_done;
  logic [63:0]        mul_prod;
  logic signed [31:0] mul_res, div_quo;
  logic [31:0]        lim32;
  logic               iter_more;
  logic signed [32:0] d00, d01, d11, dmax;
  logic [32:0]        dmag;
  logic               conv_now;

  // Operand selection.
  function automatic logic signed [31:0] pick(input src_t s);
    logic signed [31:0] val;
    case (s)
      SRC_ZERO: val = '0;
      SRC_ONE:  val = ONE;
      SRC_V:    val = v_r;
      SRC_DT:   val = 32'(time_step_r);
      SRC_L:    val = (wheelbase_r == '0) ? 32'sd1 : 32'(wheelbase_r);
      SRC_C:    val = c_r;
      SRC_B:    val = b_r;
      SRC_P00:  val = p00_r;
      SRC_P01:  val = p01_r;
      SRC_P11:  val = p11_r;
      SRC_Q1:   val = 32'(q_lateral_r);
      SRC_Q2:   val = 32'(q_heading_r);
      SRC_R:    val = 32'(r_steer_r);
      SRC_D:    val = d_r;
      SRC_Y0:   val = y0_r;
      SRC_Y1:   val = y1_r;
      SRC_TA:   val = ta_r;
      SRC_TB:   val = tb_r;
      SRC_T:    val = t_r;
      SRC_N11:  val = n11_r;
      SRC_K0:   val = k0_r;
      SRC_K1:   val = k1_r;
      SRC_E0:   val = e0_r;
      SRC_E1:   val = e1_r;
      default:  val = '0;
    endcase
    return val;
  endfunction

  assign uop = micro_rom(pc_r);

  // Operands follow both the microcode and the registers they name.
  always_comb begin
    opa = pick(uop.a);
    opb = pick(uop.b);
    opc = pick(uop.c);
  end

  // Saturating adder.
  always_comb begin
    sa = 34'(opa);
    sb = 34'(opb);
    sc = 34'(opc);
    case (uop.op)
      OP_ADD:  alu_res = sat_sum(sa + sb + sc);
      OP_SUB:  alu_res = sat_sum(sa + sb - sc);
      OP_ADDD: begin
        alu_res = sat_sum(sa + sb + sc);
        // A denominator that is not positive is taken as one LSB.
        if (alu_res <= 32'sd0) alu_res = 32'sd1;
      end
      OP_NEGS: alu_res = sat_sum(-sa - sb);
      default: alu_res = '0;
    endcase
  end

  // Convergence test on the magnitude of the largest signed change of P.
  always_comb begin
    d00 = 33'(n00_r) - 33'(p00_r);
    d01 = 33'(n01_r) - 33'(p01_r);
    d11 = 33'(n11_r) - 33'(p11_r);
    dmax = d00;
    if (d01 > dmax) dmax = d01;
    if (d11 > dmax) dmax = d11;
    dmag = dmax[32] ? 33'(-dmax) : 33'(dmax);
    conv_now = dmag <= 33'(tolerance_r);
  end

  // Loop bound, capped at the hardware limit.
  assign lim32 = (32'(max_iter_r) > 32'(ITER_LIMIT)) ? 32'(ITER_LIMIT) : 32'(max_iter_r);
  assign iter_more = (32'(n_r) < lim32) && !conv_r;

  // Shared units.
  assign mul_start = (state_r == ST_ISSUE) && (uop.op == OP_MUL || uop.op == OP_DIV);
  assign div_start = (state_r == ST_MULW) && mul_done && (uop.op == OP_DIV);

  lrsg_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .op_a     (opa),
    .op_b     (opb),
    .done     (mul_done),
    .product  (mul_prod),
    .prod_neg (mul_neg),
    .result   (mul_res)
  );

  lrsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (mul_prod + 64'(opc[31:1])),
    .den      (32'(opc)),
    .neg      (mul_neg),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Step completion and the value written back.
  always_comb begin
    step_done = 1'b0;
    wr_val    = alu_res;
    if (state_r == ST_ISSUE && uop.op != OP_MUL && uop.op != OP_DIV) begin
      step_done = 1'b1;
    end else if (state_r == ST_MULW && mul_done && uop.op == OP_MUL) begin
      step_done = 1'b1;
      wr_val    = mul_res;
    end else if (state_r == ST_DIVW && div_done) begin
      step_done = 1'b1;
      wr_val    = div_quo;
    end
    wr_en = step_done && (uop.dst != DST_NONE);
  end

  assign in_take  = (state_r == ST_IDLE) && in_valid;
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = '0;
          final_nxt = 1'b0;
        end
      end
      ST_ISSUE: begin
        if (uop.op == OP_MUL || uop.op == OP_DIV) state_nxt = ST_MULW;
      end
      ST_MULW: begin
        if (div_start) state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        state_nxt = ST_DIVW;
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (step_done) begin
      state_nxt = ST_ISSUE;
      case (uop.br)
        BR_SEQ:   pc_nxt = 5'(pc_r + 5'd1);
        BR_LOOP: begin
          pc_nxt    = PC_TERMS;
          final_nxt = !iter_more;
        end
        BR_TERMS: pc_nxt = final_r ? PC_FINAL : PC_ITER;
        BR_BACK:  pc_nxt = PC_CHECK;
        BR_END:   state_nxt = ST_HOLD;
        default:  state_nxt = ST_HOLD;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration writes. The second input weight does not reach any result,
  // since B has a zero second row, so its writes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= RST_TIME_STEP;
      wheelbase_r <= RST_WHEELBASE;
      q_lateral_r <= RST_Q_LATERAL;
      q_heading_r <= RST_Q_HEADING;
      r_steer_r   <= RST_R_STEER;
      tolerance_r <= RST_TOLERANCE;
      max_iter_r  <= RST_MAX_ITER;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP: time_step_r <= cfg_wdata[16:0];
        REG_WHEELBASE: wheelbase_r <= cfg_wdata[19:0];
        REG_Q_LATERAL: q_lateral_r <= cfg_wdata;
        REG_Q_HEADING: q_heading_r <= cfg_wdata;
        REG_R_STEER:   r_steer_r   <= cfg_wdata;
        REG_TOLERANCE: tolerance_r <= cfg_wdata;
        REG_MAX_ITER:  max_iter_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Iteration count and convergence flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      conv_r <= 1'b0;
    end else if (in_take) begin
      n_r    <= '0;
      conv_r <= 1'b0;
    end else if (step_done && uop.op == OP_COMMIT) begin
      n_r    <= n_r + NW'(1);
      conv_r <= conv_now;
    end
  end

  // Working registers: load on accept, write back on each step.
  always_ff @(posedge clk) begin
    if (in_take) begin
      v_r   <= 32'(in_speed);
      e0_r  <= 32'(in_lateral_error);
      e1_r  <= 32'(in_heading_error);
      p00_r <= 32'(q_lateral_r);
      p01_r <= '0;
      p11_r <= 32'(q_heading_r);
    end else if (step_done && uop.op == OP_COMMIT) begin
      p00_r <= n00_r;
      p01_r <= n01_r;
      p11_r <= n11_r;
    end
    if (wr_en) begin
      case (uop.dst)
        DST_C:   c_r   <= wr_val;
        DST_B:   b_r   <= wr_val;
        DST_D:   d_r   <= wr_val;
        DST_Y0:  y0_r  <= wr_val;
        DST_Y1:  y1_r  <= wr_val;
        DST_TA:  ta_r  <= wr_val;
        DST_TB:  tb_r  <= wr_val;
        DST_T:   t_r   <= wr_val;
        DST_N00: n00_r <= wr_val;
        DST_N01: n01_r <= wr_val;
        DST_N11: n11_r <= wr_val;
        DST_K0:  k0_r  <= wr_val;
        DST_K1:  k1_r  <= wr_val;
        DST_U:   u_r   <= wr_val;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmd_r  <= u_r;
      out_k0_r   <= k0_r;
      out_k1_r   <= k1_r;
      out_n_r    <= 11'(n_r);
      out_conv_r <= conv_r;
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_steer_command   = out_cmd_r;
  assign out_gain_lateral    = out_k0_r;
  assign out_gain_heading    = out_k1_r;
  assign out_iterations_done = out_n_r;
  assign out_converged       = out_conv_r;

endmodule

// File: src/lrsg_checker.sv
// ----------------------------------------------------------------------------
// lrsg_checker
// Port-level checks of the LQR steering gain unit, bound to the top level.
// ----------------------------------------------------------------------------
module lrsg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_steer_command,
  input logic [10:0]        out_iterations_done,
  input logic               out_converged
);

  // A stalled result stays valid and its steering command unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_steer_command)))
    else $error("stalled result changed");

  // An accepted transaction closes the input.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transaction");

  // Convergence can only be reported after at least one update.
  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_converged && out_iterations_done == 11'd0))
    else $error("converged with no update");

  // Reset empties the result register and opens the input.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("reset state wrong");

endmodule

bind lqr_riccati_steering_gain_unit lrsg_checker u_lrsg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_steer_command   (out_steer_command),
  .out_iterations_done (out_iterations_done),
  .out_converged       (out_converged)
);
